// ----- rtl/dda_line_stepper_with_wrap_top_macros.svh -----
// Assertion macros for the checker file of the line stepper.
`ifndef DDA_LINE_STEPPER_WITH_WRAP_TOP_MACROS_SVH
`define DDA_LINE_STEPPER_WITH_WRAP_TOP_MACROS_SVH

// Same-cycle implication, off while in reset.
`define DLS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, off while in reset.
`define DLS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

// Next-cycle implication that also runs while reset is applied.
`define DLS_ASSERT_NEXT_ALWAYS(label, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication across reset");

`endif

// ----- rtl/dls_pkg.sv -----
// Shared constants and types of the DDA line stepper.
`timescale 1ns / 1ps
`default_nettype none
package dls_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH    = 4;   // power of two
    localparam int CFG_INDEX_W    = 1;
    localparam int WIDTH_RESET    = 1024;
    localparam int HEIGHT_RESET   = 512;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        KIND_LINE  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_STEP  = 2'd2
    } kind_t;

    typedef enum logic {
        ENG_READY  = 1'b0,
        ENG_DIVIDE = 1'b1
    } eng_state_t;

endpackage
`default_nettype wire

// ----- rtl/dda_line_stepper_with_wrap_top.sv -----
// Top level of the DDA line stepper with horizontal wrap-around.
`timescale 1ns / 1ps
`default_nettype none
// A start command (s_tuser = 0) sets up a line between two endpoints, taking the route that
// wraps around the left/right image edge when that is no longer than the direct one; each step
// command (s_tuser = 1) then returns one pixel with a plot flag (strictly inside the image) and
// tlast on the final step. A start returns nothing, and so does a step when no line is active.
// Step commands are carried out at one per cycle while the output is free and no setup runs.
// A non-empty start keeps the back end busy while it loads the bit-serial divider that forms
// both increments side by side, while the FRAC_BITS + 1 quotient bits are formed and while it
// takes them up; a four-entry queue behind the input keeps taking commands meanwhile.
// Configuration index 0 is the image width, index 1 the height; write them only while idle.
module dda_line_stepper_with_wrap_top
    import dls_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // src_x, src_y, dst_x, dst_y from the lowest bit, zero fill to whole bytes
    input  wire logic [((4*COORD_BITS+7)/8)*8-1:0]     s_tdata,
    // command
    input  wire logic                                  s_tuser,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // pixel_x, pixel_y from the lowest bit, zero fill to whole bytes
    output logic [((2*COORD_BITS+7)/8)*8-1:0]          m_tdata,
    // plot
    output logic                                       m_tuser,
    output logic                                       m_tlast,
    input  wire logic                                  cfg_we,
    input  wire logic [CFG_INDEX_W-1:0]                cfg_index,
    input  wire logic [COORD_BITS:0]                   cfg_data
);

    localparam int OUT_DATA_W = ((2*COORD_BITS+7)/8)*8;

    logic [COORD_BITS:0]     width_reg;
    logic [COORD_BITS:0]     height_reg;
    logic                    q_valid;
    logic [4*COORD_BITS+5:0] q_entry;
    logic                    q_pop;
    logic [COORD_BITS-1:0]   pixel_x;
    logic [COORD_BITS-1:0]   pixel_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= (COORD_BITS+1)'(WIDTH_RESET);
            height_reg <= (COORD_BITS+1)'(HEIGHT_RESET);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    dls_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_cmd      (cmd_t'(s_tuser)),
        .src_x       (s_tdata[COORD_BITS-1:0]),
        .src_y       (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .dst_x       (s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .dst_y       (s_tdata[4*COORD_BITS-1:3*COORD_BITS]),
        .image_width (width_reg),
        .q_valid     (q_valid),
        .q_entry     (q_entry),
        .q_pop       (q_pop)
    );

    dls_engine #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_entry      (q_entry),
        .q_pop        (q_pop),
        .image_width  (width_reg),
        .image_height (height_reg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .plot         (m_tuser),
        .last         (m_tlast)
    );

    assign m_tdata = OUT_DATA_W'({pixel_y, pixel_x});

endmodule
`default_nettype wire

// ----- rtl/dls_front.sv -----
// Front end: classifies incoming commands, resolves the wrap route and queues the result.
`timescale 1ns / 1ps
`default_nettype none
module dls_front
    import dls_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire cmd_t                      in_cmd,
    input  wire logic [COORD_BITS-1:0]     src_x,
    input  wire logic [COORD_BITS-1:0]     src_y,
    input  wire logic [COORD_BITS-1:0]     dst_x,
    input  wire logic [COORD_BITS-1:0]     dst_y,
    input  wire logic [COORD_BITS:0]       image_width,
    output logic                           q_valid,
    output logic [4*COORD_BITS+5:0]        q_entry,
    input  wire logic                      q_pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        kind_t                        kind;
        logic signed [COORD_BITS+1:0] start_x;
        logic [COORD_BITS-1:0]        start_y;
        logic [COORD_BITS-1:0]        span_x;
        logic [COORD_BITS-1:0]        span_y;
        logic                         neg_x;
        logic                         neg_y;
    } entry_t;

    entry_t                entry;
    entry_t                store_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]        count_reg, count_next;
    logic                  push;
    logic                  x_fwd;
    logic                  x_ge;
    logic [COORD_BITS-1:0] dx_dir;
    logic [COORD_BITS:0]   dx_ext;
    logic [COORD_BITS:0]   gdx;
    logic                  wrap;
    logic [COORD_BITS-1:0] dy;

    // Wrapped span is |dx - width| on either ordering of the endpoints.
    always_comb
    begin
        x_fwd  = (src_x <= dst_x);
        x_ge   = (src_x >= dst_x);
        dx_dir = x_fwd ? (dst_x - src_x) : (src_x - dst_x);
        dx_ext = {1'b0, dx_dir};
        gdx    = (dx_ext >= image_width) ? (dx_ext - image_width) : (image_width - dx_ext);
        wrap   = (gdx <= dx_ext);
        dy     = (src_y <= dst_y) ? (dst_y - src_y) : (src_y - dst_y);

        entry.start_x = (wrap && !x_fwd) ? ({2'b00, src_x} - {1'b0, image_width})
                                         : {2'b00, src_x};
        entry.start_y = src_y;
        entry.span_x  = wrap ? gdx[COORD_BITS-1:0] : dx_dir;
        entry.span_y  = dy;
        if (wrap)
        begin
            entry.neg_x = x_fwd ? (dx_ext <= image_width) : (dx_ext >= image_width);
        end
        else
        begin
            entry.neg_x = x_ge;
        end
        entry.neg_y = (src_y >= dst_y);

        if (in_cmd == CMD_STEP)
        begin
            entry.kind = KIND_STEP;
        end
        else if ((entry.span_x == '0) && (dy == '0))
        begin
            entry.kind = KIND_EMPTY;
        end
        else
        begin
            entry.kind = KIND_LINE;
        end
    end

    assign in_ready = (count_reg != (PTR_W+1)'(QUEUE_DEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != '0);
    assign q_entry  = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? (wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = q_pop ? (rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg + (PTR_W+1)'(push) - (PTR_W+1)'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/dls_div.sv -----
// Bit-serial restoring divider: both increment magnitudes over one shared step count.
`timescale 1ns / 1ps
`default_nettype none
module dls_div
    import dls_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [COORD_BITS-1:0] divisor,
    input  wire logic [COORD_BITS-1:0] num_x,
    input  wire logic [COORD_BITS-1:0] num_y,
    output logic                       done,
    output logic [FRAC_BITS:0]         quo_x,
    output logic [FRAC_BITS:0]         quo_y
);

    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [COORD_BITS-1:0] div_reg;
    logic [COORD_BITS:0]   rem_x_reg, rem_x_next;
    logic [COORD_BITS:0]   rem_y_reg, rem_y_next;
    logic [FRAC_BITS:0]    quo_x_reg, quo_x_next;
    logic [FRAC_BITS:0]    quo_y_reg, quo_y_next;
    logic [COORD_BITS:0]   div_ext;
    logic                  ge_x, ge_y;
    logic [COORD_BITS:0]   sub_x, sub_y;
    logic                  last_iter;

    // Numerator never exceeds the divisor, so the quotient has one integer bit.
    always_comb
    begin
        div_ext    = {1'b0, div_reg};
        ge_x       = (rem_x_reg >= div_ext);
        ge_y       = (rem_y_reg >= div_ext);
        sub_x      = ge_x ? (rem_x_reg - div_ext) : rem_x_reg;
        sub_y      = ge_y ? (rem_y_reg - div_ext) : rem_y_reg;
        rem_x_next = {sub_x[COORD_BITS-1:0], 1'b0};
        rem_y_next = {sub_y[COORD_BITS-1:0], 1'b0};
        quo_x_next = {quo_x_reg[FRAC_BITS-1:0], ge_x};
        quo_y_next = {quo_y_reg[FRAC_BITS-1:0], ge_y};
        last_iter  = busy_reg && (cnt_reg == CNT_W'(FRAC_BITS));
        cnt_next   = cnt_reg + 1'b1;
        busy_next  = start || (busy_reg && !last_iter);
        done_next  = last_iter;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            if (start)
            begin
                cnt_reg <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg   <= divisor;
            rem_x_reg <= {1'b0, num_x};
            rem_y_reg <= {1'b0, num_y};
            quo_x_reg <= '0;
            quo_y_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_x_reg <= rem_x_next;
            rem_y_reg <= rem_y_next;
            quo_x_reg <= quo_x_next;
            quo_y_reg <= quo_y_next;
        end
    end

    assign done  = done_reg;
    assign quo_x = quo_x_reg;
    assign quo_y = quo_y_reg;

endmodule
`default_nettype wire

// ----- rtl/dls_engine.sv -----
// Back end: line setup through the divider, then one pixel per step into the output register.
`timescale 1ns / 1ps
`default_nettype none
module dls_engine
    import dls_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      q_valid,
    input  wire logic [4*COORD_BITS+5:0]   q_entry,
    output logic                           q_pop,
    input  wire logic [COORD_BITS:0]       image_width,
    input  wire logic [COORD_BITS:0]       image_height,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [COORD_BITS-1:0]          pixel_x,
    output logic [COORD_BITS-1:0]          pixel_y,
    output logic                           plot,
    output logic                           last
);

    localparam int PX_W  = COORD_BITS + 2 + FRAC_BITS;
    localparam int PY_W  = COORD_BITS + 1 + FRAC_BITS;
    localparam int INC_W = FRAC_BITS + 2;
    localparam logic [PY_W-1:0] HALF = PY_W'(1) << (FRAC_BITS - 1);

    typedef struct packed {
        kind_t                        kind;
        logic signed [COORD_BITS+1:0] start_x;
        logic [COORD_BITS-1:0]        start_y;
        logic [COORD_BITS-1:0]        span_x;
        logic [COORD_BITS-1:0]        span_y;
        logic                         neg_x;
        logic                         neg_y;
    } entry_t;

    entry_t                   head;
    eng_state_t               state_reg, state_next;
    logic                     active_reg;
    logic [COORD_BITS-1:0]    steps_left_reg;
    logic signed [PX_W-1:0]   pos_x_reg;
    logic signed [PY_W-1:0]   pos_y_reg;
    logic signed [INC_W-1:0]  inc_x_reg, inc_y_reg;
    logic                     neg_x_reg, neg_y_reg;
    logic                     out_valid_reg;
    logic [COORD_BITS-1:0]    out_x_reg, out_y_reg;
    logic                     out_plot_reg, out_last_reg;

    logic                     out_free;
    logic                     div_start;
    logic                     emit;
    logic                     div_done;
    logic [FRAC_BITS:0]       quo_x, quo_y;
    logic [COORD_BITS-1:0]    steps;
    logic signed [INC_W-1:0]  mag_x, mag_y;
    logic signed [PX_W:0]     x_lim, x_ext;
    logic signed [PY_W:0]     y_lim, y_ext;
    logic [PY_W-1:0]          y_round;
    logic                     in_image;

    assign head     = entry_t'(q_entry);
    assign steps    = (head.span_x >= head.span_y) ? head.span_x : head.span_y;
    assign out_free = !out_valid_reg || out_ready;

    dls_div #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .divisor (steps),
        .num_x   (head.span_x),
        .num_y   (head.span_y),
        .done    (div_done),
        .quo_x   (quo_x),
        .quo_y   (quo_y)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ENG_READY:
            begin
                if (q_valid && (head.kind == KIND_LINE))
                begin
                    state_next = ENG_DIVIDE;
                end
            end
            ENG_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = ENG_READY;
                end
            end
            default:
            begin
                state_next = ENG_READY;
            end
        endcase
    end

    always_comb
    begin
        q_pop     = 1'b0;
        div_start = 1'b0;
        emit      = 1'b0;
        unique case (state_reg)
            ENG_READY:
            begin
                if (q_valid)
                begin
                    unique case (head.kind)
                        KIND_LINE:
                        begin
                            q_pop     = 1'b1;
                            div_start = 1'b1;
                        end
                        KIND_EMPTY:
                        begin
                            q_pop = 1'b1;
                        end
                        KIND_STEP:
                        begin
                            // Without a line the step is dropped; otherwise wait for room.
                            if (!active_reg)
                            begin
                                q_pop = 1'b1;
                            end
                            else if (out_free)
                            begin
                                q_pop = 1'b1;
                                emit  = 1'b1;
                            end
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            ENG_DIVIDE:
            begin
                q_pop = 1'b0;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // Strictly-inside test on the exact fixed-point position.
    always_comb
    begin
        x_lim    = {2'b00, image_width, {FRAC_BITS{1'b0}}};
        x_ext    = {pos_x_reg[PX_W-1], pos_x_reg};
        y_lim    = {1'b0, image_height, {FRAC_BITS{1'b0}}};
        y_ext    = {pos_y_reg[PY_W-1], pos_y_reg};
        in_image = !pos_x_reg[PX_W-1] && (pos_x_reg != '0) && (x_ext < x_lim) &&
                   !pos_y_reg[PY_W-1] && (pos_y_reg != '0) && (y_ext < y_lim);
        y_round  = pos_y_reg + HALF;
        mag_x    = {1'b0, quo_x};
        mag_y    = {1'b0, quo_y};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ENG_READY;
            active_reg     <= 1'b0;
            steps_left_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (div_start)
            begin
                steps_left_reg <= steps;
                active_reg     <= 1'b0;
            end
            else if (q_pop && (head.kind == KIND_EMPTY))
            begin
                active_reg <= 1'b0;
            end
            else if (div_done)
            begin
                active_reg <= 1'b1;
            end
            else if (emit)
            begin
                steps_left_reg <= steps_left_reg - 1'b1;
                if (steps_left_reg == COORD_BITS'(1))
                begin
                    active_reg <= 1'b0;
                end
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            pos_x_reg <= {head.start_x, {FRAC_BITS{1'b0}}};
            pos_y_reg <= {1'b0, head.start_y, {FRAC_BITS{1'b0}}};
            neg_x_reg <= head.neg_x;
            neg_y_reg <= head.neg_y;
        end
        else if (emit)
        begin
            pos_x_reg <= pos_x_reg + {{(PX_W-INC_W){inc_x_reg[INC_W-1]}}, inc_x_reg};
            pos_y_reg <= pos_y_reg + {{(PY_W-INC_W){inc_y_reg[INC_W-1]}}, inc_y_reg};
        end

        if (div_done)
        begin
            inc_x_reg <= neg_x_reg ? -mag_x : mag_x;
            inc_y_reg <= neg_y_reg ? -mag_y : mag_y;
        end

        if (emit)
        begin
            out_plot_reg <= in_image;
            out_last_reg <= (steps_left_reg == COORD_BITS'(1));
            // Drop the coordinates of an off-image point.
            out_x_reg    <= in_image ? pos_x_reg[FRAC_BITS+COORD_BITS-1:FRAC_BITS] : '0;
            out_y_reg    <= in_image ? y_round[FRAC_BITS+COORD_BITS-1:FRAC_BITS] : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_x   = out_x_reg;
    assign pixel_y   = out_y_reg;
    assign plot      = out_plot_reg;
    assign last      = out_last_reg;

endmodule
`default_nettype wire

// ----- rtl/dls_checker.sv -----
// Port-level checker for the line stepper, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "dda_line_stepper_with_wrap_top_macros.svh"
module dls_checker
    import dls_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 s_tready,
    input wire logic                                 m_tvalid,
    input wire logic                                 m_tready,
    input wire logic [((2*COORD_BITS+7)/8)*8-1:0]    m_tdata,
    input wire logic                                 m_tuser,
    input wire logic                                 m_tlast
);

    logic [((2*COORD_BITS+7)/8)*8+1:0] m_payload;

    assign m_payload = {m_tlast, m_tuser, m_tdata};

    // A stalled result stays offered.
    `DLS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)

    // A stalled result keeps its payload.
    `DLS_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_payload))

    // Dropped points carry zero coordinates.
    `DLS_ASSERT_NOW(a_drop_zero, m_tvalid && !m_tuser, m_tdata == '0)

    // Out of reset the queue is empty and nothing is offered.
    `DLS_ASSERT_NEXT_ALWAYS(a_reset_clean, !rst_n, s_tready && !m_tvalid)

endmodule

bind dda_line_stepper_with_wrap_top dls_checker #(
    .COORD_BITS (COORD_BITS)
) u_dls_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire
